/* hdl/tnop_pkg.sv */
// telnet option negotiation parser: shared types and byte codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tnop_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_BRK  = 8'd243;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] OPT_ECHO    = 8'd1;
  localparam logic [7:0] OPT_SGA     = 8'd3;
  localparam logic [7:0] OPT_COMPORT = 8'd44;

  localparam logic [7:0] COMPORT_OFFSET = 8'd100;
  localparam int unsigned MAX_RESULTS   = 32;

  typedef enum logic [2:0] {
    MODE_DATA  = 3'd0,
    MODE_IAC   = 3'd1,
    MODE_SB    = 3'd2,
    MODE_SBIAC = 3'd3,
    MODE_WILL  = 3'd4,
    MODE_WONT  = 3'd5,
    MODE_DO    = 3'd6,
    MODE_DONT  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_RESET = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CS_IDLE   = 2'd0,
    CS_REPLY  = 2'd1,
    CS_REPLAY = 2'd2
  } ctl_state_e;

endpackage

`default_nettype wire

/* hdl/telnet_option_negotiation_parser_core.sv */
// telnet option negotiation parser: top level with command buffer memory
// depends on tnop_pkg
//
// usage
//   input stream s_axis: one received byte per transfer in tdata
//   output stream m_axis: tdata carries the data or reply byte, tuser the kind
//   (data, reply, device reset), tlast marks the final result of an input byte
//   a data byte, IAC IAC or IAC BRK gives its registered result in the cycle
//   after the transfer; with the receiver ready, data bytes pass one per cycle
//   a WILL/DO answer is three reply bytes (IAC, verb, option); the input waits meanwhile
//   a subnegotiation replay reads the command buffer, one synchronous read
//   per cycle unless the output stalls, for n buffered bytes (n at most 32)
//   while the output is stalled the read pipeline and the input both hold;
//   no byte is lost
//   reset returns the parser to data mode with an empty buffer; the buffer
//   memory itself is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module telnet_option_negotiation_parser_core
  import tnop_pkg::*;
#(
  parameter int unsigned BufferDepth = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]      m_axis_tuser_o,   // [1:0] kind
  output logic            m_axis_tlast_o    // last
);

  localparam int unsigned AW = $clog2(BufferDepth);
  localparam int unsigned CW = $clog2(BufferDepth + 1);

  // command buffer memory
  logic [7:0]    mem_q [BufferDepth];
  logic [7:0]    rd_data_q;
  logic          wr_en;
  logic [AW-1:0] wr_idx;
  logic          rd_en;

  ctl_state_e    state_q, state_d;
  mode_e         mode_q, mode_d;
  logic [CW-1:0] count_q, count_d;
  logic          comport_q, comport_d;

  logic [7:0]    verb_q, verb_d;
  logic [7:0]    opt_q, opt_d;
  logic          step_q, step_d;

  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] iss_q, iss_d;

  logic          r_valid_q, r_valid_d;
  logic          r_idx3_q, r_idx3_d;
  logic          r_last_q, r_last_d;

  logic          o_valid_q, o_valid_d;
  kind_e         o_kind_q, o_kind_d;
  logic [7:0]    o_byte_q, o_byte_d;
  logic          o_last_q, o_last_d;

  logic          o_adv;
  logic          accept;
  logic          overflow;
  mode_e         eff_mode;
  logic [CW-1:0] count_base;
  logic [CW-1:0] count_inc;
  logic [7:0]    b;

  assign b          = s_axis_tdata_i;
  assign o_adv      = !o_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == CS_IDLE) && !r_valid_q && o_adv;
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign overflow   = (count_q >= CW'(BufferDepth));
  assign eff_mode   = overflow ? MODE_DATA : mode_q;
  assign count_base = overflow ? '0 : count_q;
  assign count_inc  = count_base + CW'(1);
  assign wr_idx     = count_base[AW-1:0];
  assign wr_en      = accept;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= b;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[iss_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CS_IDLE;
      mode_q    <= MODE_DATA;
      count_q   <= '0;
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      count_q   <= count_d;
      r_valid_q <= r_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    comport_q <= comport_d;
    verb_q    <= verb_d;
    opt_q     <= opt_d;
    step_q    <= step_d;
    n_q       <= n_d;
    iss_q     <= iss_d;
    r_idx3_q  <= r_idx3_d;
    r_last_q  <= r_last_d;
    o_kind_q  <= o_kind_d;
    o_byte_q  <= o_byte_d;
    o_last_q  <= o_last_d;
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    count_d   = count_q;
    comport_d = comport_q;
    verb_d    = verb_q;
    opt_d     = opt_q;
    step_d    = step_q;
    n_d       = n_q;
    iss_d     = iss_q;
    r_valid_d = r_valid_q;
    r_idx3_d  = r_idx3_q;
    r_last_d  = r_last_q;
    o_valid_d = o_valid_q;
    o_kind_d  = o_kind_q;
    o_byte_d  = o_byte_q;
    o_last_d  = o_last_q;
    rd_en     = 1'b0;

    if (o_adv) begin
      o_valid_d = 1'b0;
    end

    // read data stage into output register
    if (r_valid_q && o_adv) begin
      o_valid_d = 1'b1;
      o_kind_d  = KIND_REPLY;
      o_byte_d  = (r_idx3_q && comport_q) ? rd_data_q + COMPORT_OFFSET : rd_data_q;
      o_last_d  = r_last_q;
      r_valid_d = 1'b0;
    end

    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          if (wr_idx == AW'(2)) begin
            comport_d = (b == OPT_COMPORT);
          end
          unique case (eff_mode)
            MODE_DATA: begin
              if (b == B_IAC) begin
                mode_d  = MODE_IAC;
                count_d = count_inc;
              end else begin
                mode_d    = MODE_DATA;
                count_d   = '0;
                o_valid_d = 1'b1;
                o_kind_d  = KIND_DATA;
                o_byte_d  = b;
                o_last_d  = 1'b1;
              end
            end
            MODE_IAC: begin
              mode_d  = MODE_DATA;
              count_d = '0;
              priority case (b)
                B_IAC: begin
                  o_valid_d = 1'b1;
                  o_kind_d  = KIND_DATA;
                  o_byte_d  = B_IAC;
                  o_last_d  = 1'b1;
                end
                B_BRK: begin
                  o_valid_d = 1'b1;
                  o_kind_d  = KIND_RESET;
                  o_byte_d  = '0;
                  o_last_d  = 1'b1;
                end
                B_SB: begin
                  mode_d  = MODE_SB;
                  count_d = count_inc;
                end
                B_WILL: begin
                  mode_d  = MODE_WILL;
                  count_d = count_inc;
                end
                B_WONT: begin
                  mode_d  = MODE_WONT;
                  count_d = count_inc;
                end
                B_DO: begin
                  mode_d  = MODE_DO;
                  count_d = count_inc;
                end
                B_DONT: begin
                  mode_d  = MODE_DONT;
                  count_d = count_inc;
                end
                default: begin
                end
              endcase
            end
            MODE_SB: begin
              count_d = count_inc;
              if (b == B_IAC) begin
                mode_d = MODE_SBIAC;
              end
            end
            MODE_SBIAC: begin
              if (b != B_SE) begin
                mode_d  = MODE_SB;
                count_d = count_inc;
              end else begin
                mode_d  = MODE_DATA;
                count_d = '0;
                if (int'(count_inc) > MAX_RESULTS) begin
                  n_d = CW'(MAX_RESULTS);
                end else begin
                  n_d = count_inc;
                end
                iss_d   = '0;
                state_d = CS_REPLAY;
              end
            end
            MODE_WILL, MODE_DO: begin
              mode_d    = MODE_DATA;
              count_d   = '0;
              opt_d     = b;
              step_d    = 1'b0;
              o_valid_d = 1'b1;
              o_kind_d  = KIND_REPLY;
              o_byte_d  = B_IAC;
              o_last_d  = 1'b0;
              state_d   = CS_REPLY;
              if (eff_mode == MODE_WILL) begin
                verb_d = (b == OPT_COMPORT) ? B_DO : B_DONT;
              end else begin
                verb_d = (b == OPT_ECHO || b == OPT_SGA || b == OPT_COMPORT) ? B_WILL : B_WONT;
              end
            end
            MODE_WONT, MODE_DONT: begin
              mode_d  = MODE_DATA;
              count_d = '0;
            end
            default: begin
              mode_d  = MODE_DATA;
              count_d = '0;
            end
          endcase
        end
      end
      CS_REPLY: begin
        if (o_adv) begin
          o_valid_d = 1'b1;
          o_kind_d  = KIND_REPLY;
          o_byte_d  = step_q ? opt_q : verb_q;
          o_last_d  = step_q;
          step_d    = 1'b1;
          if (step_q) begin
            state_d = CS_IDLE;
          end
        end
      end
      CS_REPLAY: begin
        if (!r_valid_q || o_adv) begin
          rd_en     = 1'b1;
          r_valid_d = 1'b1;
          r_idx3_d  = (iss_q == CW'(3));
          r_last_d  = (iss_q + CW'(1) == n_q);
          iss_d     = iss_q + CW'(1);
          if (iss_q + CW'(1) == n_q) begin
            state_d = CS_IDLE;
          end
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = o_byte_q;
  assign m_axis_tuser_o  = o_kind_q;
  assign m_axis_tlast_o  = o_last_q;

endmodule

`default_nettype wire

/* test/telnet_option_negotiation_parser_core_tb.sv */
// testbench for telnet_option_negotiation_parser_core: directed and random byte streams,
// with every result checked against a behavioural parser model kept in the bench
// depends on tnop_pkg and the parser core
`timescale 1ns / 1ps

module telnet_option_negotiation_parser_core_tb;
  import tnop_pkg::*;

  localparam int unsigned BufDepth = 32;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } parse_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic [7:0] s_axis_tdata_i = 8'd0;
  logic       m_axis_tready_i = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic       m_axis_tlast_o;

  // parser model state
  mode_e         parse_mode = MODE_DATA;
  logic [7:0]    cmd_buf [BufDepth];
  int unsigned   cmd_count = 0;
  parse_result_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_style = 0;
  int unsigned stall_phase = 0;

  always #6 clk_i = ~clk_i;

  telnet_option_negotiation_parser_core #(
    .BufferDepth(BufDepth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  function automatic void add_result(kind_e k, logic [7:0] v, logic l);
    parse_result_t r;
    r.kind = k;
    r.value = v;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic void enter_data_mode();
    parse_mode = MODE_DATA;
    cmd_count = 0;
  endfunction

  function automatic void add_reply3(logic [7:0] verb, logic [7:0] opt);
    add_result(KIND_REPLY, B_IAC, 1'b0);
    add_result(KIND_REPLY, verb, 1'b0);
    add_result(KIND_REPLY, opt, 1'b1);
  endfunction

  // model of one accepted input byte, pushes the results it causes
  function automatic void parse_byte(logic [7:0] b);
    mode_e       m;
    int unsigned n;
    logic        comport;
    logic [7:0]  v;
    if (cmd_count >= BufDepth) enter_data_mode();
    cmd_buf[cmd_count] = b;
    cmd_count++;
    m = parse_mode;
    case (m)
      MODE_DATA: begin
        if (b == B_IAC) begin
          parse_mode = MODE_IAC;
        end else begin
          cmd_count = 0;
          add_result(KIND_DATA, b, 1'b1);
        end
      end
      MODE_IAC: begin
        case (b)
          B_IAC: begin
            enter_data_mode();
            add_result(KIND_DATA, B_IAC, 1'b1);
          end
          B_SB:   parse_mode = MODE_SB;
          B_WILL: parse_mode = MODE_WILL;
          B_WONT: parse_mode = MODE_WONT;
          B_DO:   parse_mode = MODE_DO;
          B_DONT: parse_mode = MODE_DONT;
          B_BRK: begin
            enter_data_mode();
            add_result(KIND_RESET, 8'd0, 1'b1);
          end
          default: enter_data_mode();
        endcase
      end
      MODE_SB: begin
        if (b == B_IAC) parse_mode = MODE_SBIAC;
      end
      MODE_SBIAC: begin
        if (b != B_SE) begin
          parse_mode = MODE_SB;
        end else begin
          comport = (cmd_buf[2] == OPT_COMPORT);
          n = (cmd_count > MAX_RESULTS) ? MAX_RESULTS : cmd_count;
          for (int unsigned i = 0; i < n; i++) begin
            v = cmd_buf[i];
            if (i == 3 && comport) v = v + COMPORT_OFFSET;
            add_result(KIND_REPLY, v, (i + 1 == n));
          end
          enter_data_mode();
        end
      end
      default: begin
        enter_data_mode();
        if (m == MODE_WILL) begin
          add_reply3((b == OPT_COMPORT) ? B_DO : B_DONT, b);
        end else if (m == MODE_DO) begin
          add_reply3((b == OPT_ECHO || b == OPT_SGA || b == OPT_COMPORT) ? B_WILL : B_WONT, b);
        end
      end
    endcase
  endfunction

  // one input transfer, with bursts and random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_byte(b);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic send_negotiation(input logic [7:0] verb, input logic [7:0] opt);
    send_byte(B_IAC);
    send_byte(verb);
    send_byte(opt);
  endtask

  // iac sb opt <payload> iac se, payload bytes random or counting
  task automatic send_subneg(input logic [7:0] opt, input int unsigned len, input bit rnd);
    send_byte(B_IAC);
    send_byte(B_SB);
    send_byte(opt);
    for (int unsigned i = 0; i < len; i++)
      send_byte(rnd ? 8'($urandom_range(0, 255)) : 8'(i + 5));
    send_byte(B_IAC);
    send_byte(B_SE);
  endtask

  task automatic test_data_bytes();
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'hFE);
    send_byte(B_IAC);
    send_byte(B_IAC);
    send_byte(8'h80);
  endtask

  task automatic test_negotiation();
    send_negotiation(B_WILL, OPT_COMPORT);
    send_negotiation(B_WILL, OPT_ECHO);
    send_negotiation(B_DO, OPT_ECHO);
    send_negotiation(B_DO, OPT_SGA);
    send_negotiation(B_DO, OPT_COMPORT);
    send_negotiation(B_DO, 8'hFF);
    send_negotiation(B_WONT, 8'd5);
    send_negotiation(B_DONT, 8'd0);
  endtask

  task automatic test_break_unknown();
    send_byte(B_IAC);
    send_byte(B_BRK);
    send_byte(B_IAC);
    send_byte(8'h00);
    send_byte(B_IAC);
    send_byte(8'hF1);
    send_byte(8'h3C);
  endtask

  task automatic test_subneg();
    send_subneg(OPT_COMPORT, 2, 1'b0);
    send_subneg(OPT_ECHO, 1, 1'b0);
    // iac inside sb followed by something other than se
    send_byte(B_IAC);
    send_byte(B_SB);
    send_byte(8'd7);
    send_byte(B_IAC);
    send_byte(8'd9);
    send_byte(B_IAC);
    send_byte(B_SE);
    // shortest subnegotiation, and comport with iac as byte 3
    send_byte(B_IAC);
    send_byte(B_SB);
    send_byte(B_IAC);
    send_byte(B_SE);
    send_subneg(OPT_COMPORT, 0, 1'b0);
  endtask

  task automatic test_buffer_full();
    // buffer fills, next byte falls back to data
    send_byte(B_IAC);
    send_byte(B_SB);
    for (int unsigned i = 0; i < BufDepth - 2; i++) send_byte(8'h11);
    send_byte(8'h42);
    // longest replay
    send_subneg(OPT_COMPORT, BufDepth - 5, 1'b0);
    // se arrives with the buffer already full
    send_byte(B_IAC);
    send_byte(B_SB);
    for (int unsigned i = 0; i < BufDepth - 3; i++) send_byte(8'h22);
    send_byte(B_IAC);
    send_byte(B_SE);
  endtask

  task automatic test_random_stream(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  opt;
    logic [7:0]  verbs [4];
    logic [7:0]  opts [4];
    verbs = '{B_WILL, B_WONT, B_DO, B_DONT};
    opts = '{OPT_ECHO, OPT_SGA, OPT_COMPORT, 8'd0};
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        opt = 8'($urandom_range(0, 254));
        send_byte(opt);
        sent += 1;
      end else if (pick < 38) begin
        send_byte(B_IAC);
        send_byte(B_IAC);
        sent += 2;
      end else if (pick < 60) begin
        opts[3] = 8'($urandom_range(0, 255));
        send_negotiation(verbs[$urandom_range(0, 3)], opts[$urandom_range(0, 3)]);
        sent += 3;
      end else if (pick < 65) begin
        send_byte(B_IAC);
        send_byte(B_BRK);
        sent += 2;
      end else if (pick < 82) begin
        opt = ($urandom_range(0, 1) != 0) ? OPT_COMPORT : 8'($urandom_range(0, 255));
        pick = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 6);
        send_subneg(opt, pick, 1'b1);
        sent += pick + 5;
      end else if (pick < 88) begin
        send_byte(B_IAC);
        send_byte(8'($urandom_range(0, 242)));
        sent += 2;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent += 1;
      end
    end
  endtask

  // receiver ready: switches between styles of stalling
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 97 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= ($urandom_range(0, 9) < 3);
      default: m_axis_tready_i <= (stall_phase[2:0] < 3'd5);
    endcase
  end

  // result checker, one transfer per edge
  always @(posedge clk_i) begin
    parse_result_t seen;
    parse_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen.kind = m_axis_tuser_o;
      seen.value = m_axis_tdata_o;
      seen.last = m_axis_tlast_o;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result kind %0d byte %02h last %0d",
                   seen.kind, seen.value, seen.last);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected kind %0d byte %02h last %0d, ",
                      "got kind %0d byte %02h last %0d"},
                     want.kind, want.value, want.last, seen.kind, seen.value, seen.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_data_bytes();
    test_negotiation();
    test_break_unknown();
    wait_drained();
    test_subneg();
    test_buffer_full();
    wait_drained();
    test_random_stream(20);
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* telnet_option_negotiation_parser_core.f */
hdl/tnop_pkg.sv
hdl/telnet_option_negotiation_parser_core.sv
test/telnet_option_negotiation_parser_core_tb.sv
